FILE: sv/jst_pkg.sv
// ----------------------------------------------------------------------------
// jst_pkg
// Shared types and constants for the streaming JSON tokenizer.
// ----------------------------------------------------------------------------
package jst_pkg;

  localparam int MAX_NEST = 256;
  localparam int DEPTH_W  = $clog2(MAX_NEST + 1);
  localparam int ADDR_W   = $clog2(MAX_NEST);
  localparam int MAX_RES  = 6;
  localparam int CNT_W    = 3;

  typedef enum logic [3:0] {
    TK_OBJSTART = 4'd0,
    TK_OBJEND   = 4'd1,
    TK_ARRSTART = 4'd2,
    TK_ARREND   = 4'd3,
    TK_KEY      = 4'd4,
    TK_STRING   = 4'd5,
    TK_NUMBER   = 4'd6,
    TK_BOOL     = 4'd7,
    TK_NULL     = 4'd8,
    TK_END      = 4'd9,
    TK_ERROR    = 4'd10
  } token_t;

  typedef enum logic [3:0] {
    ER_NONE       = 4'd0,
    ER_UNEXPECTED = 4'd1,
    ER_LITERAL    = 4'd2,
    ER_NUMBER     = 4'd3,
    ER_ESCAPE     = 4'd4,
    ER_UNICODE    = 4'd5,
    ER_SURROGATE  = 4'd6,
    ER_UNTERM_STR = 4'd7,
    ER_DEPTH      = 4'd8,
    ER_UNTERM_ESC = 4'd9
  } err_t;

  typedef enum logic [3:0] {
    MD_IDLE, MD_STR, MD_ESC, MD_HEX, MD_PAIR_BS, MD_PAIR_U, MD_LO_HEX,
    MD_NUM_SIGN, MD_NUM_INT, MD_NUM_FRAC, MD_NUM_EXP_START, MD_NUM_EXP,
    MD_LIT_T, MD_LIT_F, MD_LIT_N
  } mode_t;

  typedef struct packed {
    logic               kind;
    token_t             token;
    logic [7:0]         vbyte;
    logic               bval;
    logic [DEPTH_W-1:0] depth;
    err_t               ecode;
  } result_t;

  typedef result_t [MAX_RES-1:0] res_list_t;

  typedef struct packed {
    logic push;
    logic pop;
    logic obj;
  } stk_op_t;

endpackage

FILE: sv/jst_stack.sv
// ----------------------------------------------------------------------------
// jst_stack
// Object/array stack, one bit per depth, with the top two entries at hand.
// ----------------------------------------------------------------------------
module jst_stack (
  input  logic                        clk,
  input  logic                        rst,
  input  jst_pkg::stk_op_t            op,
  input  logic [jst_pkg::DEPTH_W-1:0] depth_cur,
  input  logic [jst_pkg::DEPTH_W-1:0] depth_next,
  output logic                        top,
  output logic                        below
);

  logic                       mem [jst_pkg::MAX_NEST];
  logic [jst_pkg::DEPTH_W-1:0] rd_full;
  logic [jst_pkg::ADDR_W-1:0]  rd_addr;

  // The entry under the top is read every cycle for the depth of the next one.
  assign rd_full = depth_next - jst_pkg::DEPTH_W'(2);
  assign rd_addr = rd_full[jst_pkg::ADDR_W-1:0];

  always_ff @(posedge clk) begin
    if (op.push) begin
      mem[depth_cur[jst_pkg::ADDR_W-1:0]] <= op.obj;
    end
    below <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      top <= 1'b0;
    end else if (op.push) begin
      top <= op.obj;
    end else if (op.pop) begin
      top <= below;
    end
  end

endmodule

FILE: sv/jst_core.sv
// ----------------------------------------------------------------------------
// jst_core
// Lexer state and the combinational step that turns one beat into results.
// ----------------------------------------------------------------------------
module jst_core (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        take,
  input  logic [7:0]                  in_byte,
  input  logic                        end_of_input,
  input  logic                        top,
  input  logic                        below,
  output jst_pkg::res_list_t          res,
  output logic [jst_pkg::CNT_W-1:0]   res_cnt,
  output jst_pkg::stk_op_t            op,
  output logic [jst_pkg::DEPTH_W-1:0] depth_cur,
  output logic [jst_pkg::DEPTH_W-1:0] depth_next
);

  localparam logic [7:0] CH_QUOTE = 8'h22;
  localparam logic [7:0] CH_BSL   = 8'h5C;

  typedef struct packed {
    logic [jst_pkg::DEPTH_W-1:0] depth;
    logic                        key_due;
    jst_pkg::mode_t              mode;
    logic [1:0]                  sep;
    logic [15:0]                 hex;
    logic [15:0]                 hi;
    logic [2:0]                  hcnt;
    logic [2:0]                  lidx;
    logic                        is_key;
    logic                        stopped;
  } st_t;

  typedef struct packed {
    st_t                       s;
    jst_pkg::stk_op_t          op;
    jst_pkg::res_list_t        res;
    logic [jst_pkg::CNT_W-1:0] cnt;
  } work_t;

  localparam st_t ST_RESET = '{depth: '0, key_due: 1'b0, mode: jst_pkg::MD_IDLE,
                               sep: 2'd0, hex: 16'd0, hi: 16'd0, hcnt: 3'd0,
                               lidx: 3'd0, is_key: 1'b0, stopped: 1'b0};

  st_t   st;
  work_t w;

  function automatic work_t put(work_t w0, logic kind, jst_pkg::token_t tok,
                                logic [7:0] vb, logic bv, jst_pkg::err_t ec);
    work_t r;
    r = w0;
    if (r.cnt < jst_pkg::CNT_W'(jst_pkg::MAX_RES)) begin
      r.res[r.cnt] = '{kind: kind, token: tok, vbyte: vb, bval: bv,
                       depth: r.s.depth, ecode: ec};
      r.cnt = r.cnt + jst_pkg::CNT_W'(1);
    end
    return r;
  endfunction

  function automatic work_t raise(work_t w0, jst_pkg::err_t ec);
    work_t r;
    r = put(w0, 1'b1, jst_pkg::TK_ERROR, 8'd0, 1'b0, ec);
    r.s.stopped = 1'b1;
    r.s.mode    = jst_pkg::MD_IDLE;
    return r;
  endfunction

  // After a pop the entry below the old top is the new top.
  function automatic logic in_obj(work_t w0);
    if (w0.s.depth == '0) return 1'b0;
    return w0.op.pop ? below : top;
  endfunction

  function automatic jst_pkg::token_t text_tok(work_t w0);
    return w0.s.is_key ? jst_pkg::TK_KEY : jst_pkg::TK_STRING;
  endfunction

  function automatic work_t emit_cp(work_t w0, logic [20:0] cp);
    work_t           r;
    jst_pkg::token_t t;
    r = w0;
    t = text_tok(w0);
    if (cp < 21'h80) begin
      r = put(r, 1'b0, t, cp[7:0], 1'b0, jst_pkg::ER_NONE);
    end else if (cp < 21'h800) begin
      r = put(r, 1'b0, t, {3'b110, cp[10:6]}, 1'b0, jst_pkg::ER_NONE);
      r = put(r, 1'b0, t, {2'b10, cp[5:0]}, 1'b0, jst_pkg::ER_NONE);
    end else if (cp < 21'h10000) begin
      r = put(r, 1'b0, t, {4'b1110, cp[15:12]}, 1'b0, jst_pkg::ER_NONE);
      r = put(r, 1'b0, t, {2'b10, cp[11:6]}, 1'b0, jst_pkg::ER_NONE);
      r = put(r, 1'b0, t, {2'b10, cp[5:0]}, 1'b0, jst_pkg::ER_NONE);
    end else begin
      r = put(r, 1'b0, t, {5'b11110, cp[20:18]}, 1'b0, jst_pkg::ER_NONE);
      r = put(r, 1'b0, t, {2'b10, cp[17:12]}, 1'b0, jst_pkg::ER_NONE);
      r = put(r, 1'b0, t, {2'b10, cp[11:6]}, 1'b0, jst_pkg::ER_NONE);
      r = put(r, 1'b0, t, {2'b10, cp[5:0]}, 1'b0, jst_pkg::ER_NONE);
    end
    return r;
  endfunction

  function automatic logic is_digit(logic [7:0] b);
    return (b >= 8'h30) && (b <= 8'h39);
  endfunction

  function automatic work_t idle_byte(work_t w0, logic [7:0] b);
    work_t r;
    r = w0;
    if (b == 8'h20 || b == 8'h09 || b == 8'h0A || b == 8'h0D) return r;
    if (b == 8'h2C) begin
      if (r.s.sep == 2'd0) r.s.sep = 2'd1;
      else r = raise(r, jst_pkg::ER_UNEXPECTED);
      return r;
    end
    if (b == 8'h3A) begin
      if (r.s.sep < 2'd2) r.s.sep = 2'd2;
      else r = raise(r, jst_pkg::ER_UNEXPECTED);
      return r;
    end
    r.s.sep = 2'd0;
    case (b)
      CH_QUOTE: begin
        r.s.is_key = in_obj(r) && r.s.key_due;
        r.s.mode   = jst_pkg::MD_STR;
      end
      8'h7B, 8'h5B: begin
        if (r.s.depth >= jst_pkg::DEPTH_W'(jst_pkg::MAX_NEST)) begin
          r = raise(r, jst_pkg::ER_DEPTH);
        end else begin
          r.op.push       = 1'b1;
          r.op.obj        = (b == 8'h7B);
          r.s.depth       = r.s.depth + jst_pkg::DEPTH_W'(1);
          r.s.key_due     = (b == 8'h7B);
          r = put(r, 1'b1, (b == 8'h7B) ? jst_pkg::TK_OBJSTART : jst_pkg::TK_ARRSTART,
                  8'd0, 1'b0, jst_pkg::ER_NONE);
        end
      end
      8'h7D, 8'h5D: begin
        if (r.s.depth != '0) begin
          r.op.pop  = 1'b1;
          r.s.depth = r.s.depth - jst_pkg::DEPTH_W'(1);
        end
        r.s.key_due = in_obj(r);
        r = put(r, 1'b1, (b == 8'h7D) ? jst_pkg::TK_OBJEND : jst_pkg::TK_ARREND,
                8'd0, 1'b0, jst_pkg::ER_NONE);
      end
      8'h74: begin r.s.mode = jst_pkg::MD_LIT_T; r.s.lidx = 3'd1; end
      8'h66: begin r.s.mode = jst_pkg::MD_LIT_F; r.s.lidx = 3'd1; end
      8'h6E: begin r.s.mode = jst_pkg::MD_LIT_N; r.s.lidx = 3'd1; end
      8'h2D: begin
        r.s.mode = jst_pkg::MD_NUM_SIGN;
        r = put(r, 1'b0, jst_pkg::TK_NUMBER, b, 1'b0, jst_pkg::ER_NONE);
      end
      default: begin
        if (is_digit(b)) begin
          r.s.mode = jst_pkg::MD_NUM_INT;
          r = put(r, 1'b0, jst_pkg::TK_NUMBER, b, 1'b0, jst_pkg::ER_NONE);
        end else begin
          r = raise(r, jst_pkg::ER_UNEXPECTED);
        end
      end
    endcase
    return r;
  endfunction

  function automatic work_t string_byte(work_t w0, logic [7:0] b);
    work_t r;
    r = w0;
    if (b == CH_QUOTE) begin
      r = put(r, 1'b1, text_tok(r), 8'd0, 1'b0, jst_pkg::ER_NONE);
      r.s.key_due = r.s.is_key ? 1'b0 : in_obj(r);
      r.s.mode = jst_pkg::MD_IDLE;
    end else if (b == CH_BSL) begin
      r.s.mode = jst_pkg::MD_ESC;
    end else begin
      r = put(r, 1'b0, text_tok(r), b, 1'b0, jst_pkg::ER_NONE);
    end
    return r;
  endfunction

  function automatic work_t escape_byte(work_t w0, logic [7:0] b);
    work_t      r;
    logic [7:0] v;
    logic       ok;
    r  = w0;
    ok = 1'b1;
    v  = b;
    case (b)
      CH_QUOTE, CH_BSL, 8'h2F: v = b;
      8'h62: v = 8'h08;
      8'h66: v = 8'h0C;
      8'h6E: v = 8'h0A;
      8'h72: v = 8'h0D;
      8'h74: v = 8'h09;
      default: ok = 1'b0;
    endcase
    if (b == 8'h75) begin
      r.s.mode = jst_pkg::MD_HEX;
      r.s.hex  = 16'd0;
      r.s.hcnt = 3'd0;
    end else if (!ok) begin
      r = raise(r, jst_pkg::ER_ESCAPE);
    end else begin
      r = put(r, 1'b0, text_tok(r), v, 1'b0, jst_pkg::ER_NONE);
      r.s.mode = jst_pkg::MD_STR;
    end
    return r;
  endfunction

  function automatic work_t hex_byte(work_t w0, logic [7:0] b, logic low);
    work_t       r;
    logic [3:0]  v;
    logic        ok;
    logic [20:0] cp;
    r  = w0;
    ok = 1'b1;
    v  = 4'd0;
    if (is_digit(b)) v = b[3:0];
    else if ((b >= 8'h61 && b <= 8'h66) || (b >= 8'h41 && b <= 8'h46))
      v = b[3:0] + 4'd9;
    else ok = 1'b0;
    if (!ok) return raise(r, low ? jst_pkg::ER_SURROGATE : jst_pkg::ER_UNICODE);
    r.s.hex  = {r.s.hex[11:0], v};
    r.s.hcnt = r.s.hcnt + 3'd1;
    if (r.s.hcnt < 3'd4) return r;
    if (!low) begin
      if (r.s.hex >= 16'hD800 && r.s.hex <= 16'hDBFF) begin
        r.s.hi   = r.s.hex;
        r.s.mode = jst_pkg::MD_PAIR_BS;
      end else begin
        r = emit_cp(r, {5'd0, r.s.hex});
        r.s.mode = jst_pkg::MD_STR;
      end
      return r;
    end
    if (r.s.hex < 16'hDC00 || r.s.hex > 16'hDFFF) return raise(r, jst_pkg::ER_SURROGATE);
    cp = 21'h10000 + {1'b0, r.s.hi[9:0], r.s.hex[9:0]};
    r = emit_cp(r, cp);
    r.s.mode = jst_pkg::MD_STR;
    return r;
  endfunction

  function automatic work_t finish_number(work_t w0, logic [7:0] b);
    work_t r;
    r = put(w0, 1'b1, jst_pkg::TK_NUMBER, 8'd0, 1'b0, jst_pkg::ER_NONE);
    r.s.key_due = in_obj(r);
    r.s.mode = jst_pkg::MD_IDLE;
    return idle_byte(r, b);
  endfunction

  function automatic work_t number_byte(work_t w0, logic [7:0] b);
    work_t r;
    logic  d;
    logic  e;
    r = w0;
    d = is_digit(b);
    e = (b == 8'h65) || (b == 8'h45);
    case (r.s.mode)
      jst_pkg::MD_NUM_SIGN: begin
        if (!d) return raise(r, jst_pkg::ER_NUMBER);
        r.s.mode = jst_pkg::MD_NUM_INT;
      end
      jst_pkg::MD_NUM_INT: begin
        if (b == 8'h2E) r.s.mode = jst_pkg::MD_NUM_FRAC;
        else if (e) r.s.mode = jst_pkg::MD_NUM_EXP_START;
        else if (!d) return finish_number(r, b);
      end
      jst_pkg::MD_NUM_FRAC: begin
        if (e) r.s.mode = jst_pkg::MD_NUM_EXP_START;
        else if (!d) return finish_number(r, b);
      end
      jst_pkg::MD_NUM_EXP_START: begin
        if (d || b == 8'h2B || b == 8'h2D) r.s.mode = jst_pkg::MD_NUM_EXP;
        else return finish_number(r, b);
      end
      default: begin
        if (!d) return finish_number(r, b);
      end
    endcase
    return put(r, 1'b0, jst_pkg::TK_NUMBER, b, 1'b0, jst_pkg::ER_NONE);
  endfunction

  function automatic logic [7:0] lit_char(logic [1:0] k, logic [2:0] i);
    logic [39:0] txt;
    case (k)
      2'd0:    txt = {8'h00, 8'h65, 8'h75, 8'h72, 8'h74};
      2'd1:    txt = {8'h65, 8'h73, 8'h6C, 8'h61, 8'h66};
      default: txt = {8'h00, 8'h6C, 8'h6C, 8'h75, 8'h6E};
    endcase
    return (i < 3'd5) ? txt[i*8 +: 8] : 8'h00;
  endfunction

  function automatic work_t literal_byte(work_t w0, logic [7:0] b);
    work_t      r;
    logic [1:0] k;
    logic [2:0] len;
    r = w0;
    case (r.s.mode)
      jst_pkg::MD_LIT_T: k = 2'd0;
      jst_pkg::MD_LIT_F: k = 2'd1;
      default:           k = 2'd2;
    endcase
    len = (k == 2'd1) ? 3'd5 : 3'd4;
    if (r.s.lidx >= len || b != lit_char(k, r.s.lidx)) return raise(r, jst_pkg::ER_LITERAL);
    r.s.lidx = r.s.lidx + 3'd1;
    if (r.s.lidx < len) return r;
    if (k == 2'd2) r = put(r, 1'b1, jst_pkg::TK_NULL, 8'd0, 1'b0, jst_pkg::ER_NONE);
    else r = put(r, 1'b1, jst_pkg::TK_BOOL, 8'd0, (k == 2'd0), jst_pkg::ER_NONE);
    r.s.key_due = in_obj(r);
    r.s.mode = jst_pkg::MD_IDLE;
    return r;
  endfunction

  function automatic work_t end_doc(work_t w0);
    work_t r;
    r = w0;
    if (!r.s.stopped) begin
      case (r.s.mode)
        jst_pkg::MD_IDLE:    r = r;
        jst_pkg::MD_STR:     r = raise(r, jst_pkg::ER_UNTERM_STR);
        jst_pkg::MD_ESC:     r = raise(r, jst_pkg::ER_UNTERM_ESC);
        jst_pkg::MD_HEX:     r = raise(r, jst_pkg::ER_UNICODE);
        jst_pkg::MD_PAIR_BS: begin
          r = emit_cp(r, {5'd0, r.s.hi});
          r = raise(r, jst_pkg::ER_UNTERM_STR);
        end
        jst_pkg::MD_PAIR_U: begin
          r = emit_cp(r, {5'd0, r.s.hi});
          r = raise(r, jst_pkg::ER_UNTERM_ESC);
        end
        jst_pkg::MD_LO_HEX:   r = raise(r, jst_pkg::ER_SURROGATE);
        jst_pkg::MD_NUM_SIGN: r = raise(r, jst_pkg::ER_NUMBER);
        jst_pkg::MD_NUM_INT, jst_pkg::MD_NUM_FRAC, jst_pkg::MD_NUM_EXP_START,
        jst_pkg::MD_NUM_EXP:
          r = put(r, 1'b1, jst_pkg::TK_NUMBER, 8'd0, 1'b0, jst_pkg::ER_NONE);
        default: r = raise(r, jst_pkg::ER_LITERAL);
      endcase
    end
    r = put(r, 1'b1, jst_pkg::TK_END, 8'd0, 1'b0, jst_pkg::ER_NONE);
    r.s = ST_RESET;
    return r;
  endfunction

  always_comb begin
    w     = '0;
    w.s   = st;
    if (end_of_input) begin
      w = end_doc(w);
    end else if (!st.stopped) begin
      case (st.mode)
        jst_pkg::MD_IDLE: w = idle_byte(w, in_byte);
        jst_pkg::MD_STR:  w = string_byte(w, in_byte);
        jst_pkg::MD_ESC:  w = escape_byte(w, in_byte);
        jst_pkg::MD_HEX:  w = hex_byte(w, in_byte, 1'b0);
        jst_pkg::MD_PAIR_BS: begin
          if (in_byte == CH_BSL) begin
            w.s.mode = jst_pkg::MD_PAIR_U;
          end else begin
            w = emit_cp(w, {5'd0, st.hi});
            w.s.mode = jst_pkg::MD_STR;
            w = string_byte(w, in_byte);
          end
        end
        jst_pkg::MD_PAIR_U: begin
          if (in_byte == 8'h75) begin
            w.s.mode = jst_pkg::MD_LO_HEX;
            w.s.hex  = 16'd0;
            w.s.hcnt = 3'd0;
          end else begin
            w = emit_cp(w, {5'd0, st.hi});
            w.s.mode = jst_pkg::MD_STR;
            w = escape_byte(w, in_byte);
          end
        end
        jst_pkg::MD_LO_HEX: w = hex_byte(w, in_byte, 1'b1);
        jst_pkg::MD_NUM_SIGN, jst_pkg::MD_NUM_INT, jst_pkg::MD_NUM_FRAC,
        jst_pkg::MD_NUM_EXP_START, jst_pkg::MD_NUM_EXP:
          w = number_byte(w, in_byte);
        jst_pkg::MD_LIT_T, jst_pkg::MD_LIT_F, jst_pkg::MD_LIT_N:
          w = literal_byte(w, in_byte);
        default: begin
          w.s.mode = jst_pkg::MD_IDLE;
          w = idle_byte(w, in_byte);
        end
      endcase
    end
  end

  assign res        = w.res;
  assign res_cnt    = w.cnt;
  assign depth_cur  = st.depth;
  assign depth_next = take ? w.s.depth : st.depth;
  assign op         = take ? w.op : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      st <= ST_RESET;
    end else if (take) begin
      st <= w.s;
    end
  end

endmodule

FILE: sv/jst_obuf.sv
// ----------------------------------------------------------------------------
// jst_obuf
// Result register: holds one beat's results; sends one a cycle if m_tready.
// ----------------------------------------------------------------------------
module jst_obuf (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      load,
  input  jst_pkg::res_list_t        res,
  input  logic [jst_pkg::CNT_W-1:0] res_cnt,
  output logic                      free,
  output logic                      m_tvalid,
  input  logic                      m_tready,
  output logic [31:0]               m_tdata,
  output logic                      m_tuser,
  output logic                      m_tlast
);

  jst_pkg::res_list_t        list;
  logic [jst_pkg::CNT_W-1:0] cnt;
  logic [jst_pkg::CNT_W-1:0] idx;
  jst_pkg::result_t          cur;
  logic                      at_last;

  assign cur      = list[idx];
  assign m_tvalid = idx < cnt;
  assign at_last  = idx == (cnt - jst_pkg::CNT_W'(1));
  assign free     = !m_tvalid || (m_tready && at_last);
  assign m_tlast  = at_last;
  assign m_tuser  = cur.kind;
  assign m_tdata  = {6'd0, cur.ecode, cur.depth, cur.bval, cur.vbyte, cur.token};

  always_ff @(posedge clk) begin
    if (load) begin
      list <= res;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
      idx <= '0;
    end else if (load) begin
      cnt <= res_cnt;
      idx <= '0;
    end else if (m_tvalid && m_tready) begin
      idx <= idx + jst_pkg::CNT_W'(1);
    end
  end

endmodule

FILE: sv/json_stream_tokenizer.sv
// ----------------------------------------------------------------------------
// json_stream_tokenizer
// Streaming JSON tokenizer: one byte per beat in, token events and decoded
// value bytes out.
// ----------------------------------------------------------------------------
//  channel | dir | tdata                    | tuser    | tlast
//  s_*     | in  | [7:0] input byte         | -        | end of document
//  m_*     | out | token, byte, bool, depth,| out_kind | last result of beat
//          |     | error code               |          |
//
// A beat enters an input register, is decoded combinationally against the
// lexer state and the two top stack entries, and its zero to five results
// land in a result register that sends one result per cycle while m_tready
// is high. A beat with at most one result then passes at one beat per cycle;
// a beat with more results holds the input until the single output port has sent them.
// Reset (rst, synchronous) clears the lexer state, depth and queues; the stack
// memory is not cleared. A stall on m_tready backs up into s_tready.
module json_stream_tokenizer (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] in_byte
  input  logic        s_tlast,   // end_of_input
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata,   // [3:0] token, [11:4] value_byte, [12] true flag,
                                 // [21:13] nest_depth, [25:22] error_code
  output logic        m_tuser,   // out_kind
  output logic        m_tlast    // last_of_run
);

  logic                        ivalid;
  logic [7:0]                  ibyte;
  logic                        ilast;
  logic                        take;
  logic                        free;
  logic                        top;
  logic                        below;
  jst_pkg::res_list_t          res;
  logic [jst_pkg::CNT_W-1:0]   res_cnt;
  jst_pkg::stk_op_t            op;
  logic [jst_pkg::DEPTH_W-1:0] depth_cur;
  logic [jst_pkg::DEPTH_W-1:0] depth_next;

  // A beat with no results never waits for the result register.
  assign take     = ivalid && ((res_cnt == '0) || free);
  assign s_tready = !ivalid || take;

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      ibyte <= s_tdata;
      ilast <= s_tlast;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ivalid <= 1'b0;
    end else if (s_tready) begin
      ivalid <= s_tvalid;
    end
  end

  jst_core u_core (
    .clk          (clk),
    .rst          (rst),
    .take         (take),
    .in_byte      (ibyte),
    .end_of_input (ilast),
    .top          (top),
    .below        (below),
    .res          (res),
    .res_cnt      (res_cnt),
    .op           (op),
    .depth_cur    (depth_cur),
    .depth_next   (depth_next)
  );

  jst_stack u_stack (
    .clk        (clk),
    .rst        (rst),
    .op         (op),
    .depth_cur  (depth_cur),
    .depth_next (depth_next),
    .top        (top),
    .below      (below)
  );

  jst_obuf u_obuf (
    .clk      (clk),
    .rst      (rst),
    .load     (take && (res_cnt != '0)),
    .res      (res),
    .res_cnt  (res_cnt),
    .free     (free),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

endmodule

FILE: tb/json_stream_tokenizer_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// json_stream_tokenizer_tb
// Self-checking bench for the streaming JSON tokenizer. A queue of input
// beats (directed corner cases, one deep-nesting document and random
// documents with some corruption and noise) feeds a clocked driver with
// random gaps. Each accepted beat runs through an in-bench tokenizer model
// that queues the expected results, and a clocked monitor with random stalls
// checks every output beat against the oldest entry.
// ----------------------------------------------------------------------------
module json_stream_tokenizer_tb;
  import jst_pkg::*;

  typedef struct {
    logic [7:0] data;
    logic       eod;
  } in_beat_t;

  typedef struct {
    logic       kind;
    token_t     tok;
    logic [7:0] vb;
    logic       bv;
    logic [8:0] dp;
    err_t       ec;
    logic       last;
  } tok_res_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [7:0]  s_tdata = 8'd0;
  logic        s_tlast = 1'b0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [31:0] m_tdata;
  logic        m_tuser;
  logic        m_tlast;

  in_beat_t pending_beats[$];
  tok_res_t expected_results[$];
  int       mismatches = 0;
  int       results_seen = 0;
  int       quiet_after = 0;
  int       beats_sent = 0;
  int       tx_gap = 0;
  int       rx_gap = 0;
  int       hold_cnt = 0;
  bit       hold_done = 0;
  int       idle_cycles = 0;

  // Model state of the tokenizer.
  int         depth;
  bit         obj_stk[MAX_NEST];
  bit         want_key;
  mode_t      mode;
  int         sep;
  logic [15:0] hacc;
  logic [15:0] hsur;
  int         hcnt;
  int         lidx;
  bit         in_key;
  bit         stopped;
  int         step_cnt;

  json_stream_tokenizer dut (.*);

  always #2 clk = ~clk;

  task automatic put_res(logic kind, token_t tok, logic [7:0] vb, logic bv, err_t ec);
    tok_res_t r;
    if (step_cnt < MAX_RES) begin
      r.kind = kind; r.tok = tok; r.vb = vb; r.bv = bv;
      r.dp = depth[8:0]; r.ec = ec; r.last = 1'b0;
      expected_results.push_back(r);
      step_cnt++;
    end
  endtask

  task automatic put_event(token_t tok, logic bv);
    put_res(1'b1, tok, 8'd0, bv, ER_NONE);
  endtask

  task automatic put_byte(token_t tok, logic [7:0] b);
    put_res(1'b0, tok, b, 1'b0, ER_NONE);
  endtask

  task automatic raise(err_t ec);
    put_res(1'b1, TK_ERROR, 8'd0, 1'b0, ec);
    stopped = 1;
    mode = MD_IDLE;
  endtask

  function automatic bit in_obj_now();
    if (depth == 0 || depth > MAX_NEST) return 0;
    return obj_stk[depth-1];
  endfunction

  function automatic token_t text_tok();
    return in_key ? TK_KEY : TK_STRING;
  endfunction

  task automatic put_codepoint(int unsigned cp);
    token_t t;
    t = text_tok();
    if (cp < 'h80) begin
      put_byte(t, cp[7:0]);
    end else if (cp < 'h800) begin
      put_byte(t, 8'(8'hC0 | (cp >> 6)));
      put_byte(t, 8'(8'h80 | (cp & 'h3F)));
    end else if (cp < 'h10000) begin
      put_byte(t, 8'(8'hE0 | (cp >> 12)));
      put_byte(t, 8'(8'h80 | ((cp >> 6) & 'h3F)));
      put_byte(t, 8'(8'h80 | (cp & 'h3F)));
    end else begin
      put_byte(t, 8'(8'hF0 | (cp >> 18)));
      put_byte(t, 8'(8'h80 | ((cp >> 12) & 'h3F)));
      put_byte(t, 8'(8'h80 | ((cp >> 6) & 'h3F)));
      put_byte(t, 8'(8'h80 | (cp & 'h3F)));
    end
  endtask

  function automatic bit is_dig(logic [7:0] b);
    return b >= "0" && b <= "9";
  endfunction

  task automatic between_tokens(logic [7:0] b);
    if (b == " " || b == 8'h09 || b == 8'h0A || b == 8'h0D) return;
    if (b == ",") begin
      if (sep == 0) sep = 1; else raise(ER_UNEXPECTED);
      return;
    end
    if (b == ":") begin
      if (sep < 2) sep = 2; else raise(ER_UNEXPECTED);
      return;
    end
    sep = 0;
    case (b)
      "\"": begin
        in_key = in_obj_now() && want_key;
        mode = MD_STR;
      end
      "{", "[": begin
        if (depth >= MAX_NEST) begin
          raise(ER_DEPTH);
        end else begin
          depth++;
          obj_stk[depth-1] = (b == "{");
          want_key = (b == "{");
          put_event(b == "{" ? TK_OBJSTART : TK_ARRSTART, 1'b0);
        end
      end
      "}", "]": begin
        if (depth > 0) begin
          obj_stk[depth-1] = 0;
          depth--;
        end
        want_key = in_obj_now();
        put_event(b == "}" ? TK_OBJEND : TK_ARREND, 1'b0);
      end
      "t": begin mode = MD_LIT_T; lidx = 1; end
      "f": begin mode = MD_LIT_F; lidx = 1; end
      "n": begin mode = MD_LIT_N; lidx = 1; end
      "-": begin mode = MD_NUM_SIGN; put_byte(TK_NUMBER, b); end
      default: begin
        if (is_dig(b)) begin
          mode = MD_NUM_INT;
          put_byte(TK_NUMBER, b);
        end else begin
          raise(ER_UNEXPECTED);
        end
      end
    endcase
  endtask

  task automatic string_char(logic [7:0] b);
    if (b == "\"") begin
      put_event(text_tok(), 1'b0);
      want_key = in_key ? 0 : in_obj_now();
      mode = MD_IDLE;
    end else if (b == "\\") begin
      mode = MD_ESC;
    end else begin
      put_byte(text_tok(), b);
    end
  endtask

  task automatic escape_char(logic [7:0] b);
    logic [7:0] v;
    case (b)
      "\"", "\\", "/": v = b;
      "b": v = 8'h08;
      "f": v = 8'h0C;
      "n": v = 8'h0A;
      "r": v = 8'h0D;
      "t": v = 8'h09;
      "u": begin
        mode = MD_HEX; hacc = 0; hcnt = 0;
        return;
      end
      default: begin
        raise(ER_ESCAPE);
        return;
      end
    endcase
    put_byte(text_tok(), v);
    mode = MD_STR;
  endtask

  task automatic close_number(logic [7:0] b);
    put_event(TK_NUMBER, 1'b0);
    want_key = in_obj_now();
    mode = MD_IDLE;
    between_tokens(b);
  endtask

  task automatic number_char(logic [7:0] b);
    bit d, e;
    d = is_dig(b);
    e = (b == "e" || b == "E");
    case (mode)
      MD_NUM_SIGN: begin
        if (!d) begin raise(ER_NUMBER); return; end
        mode = MD_NUM_INT;
      end
      MD_NUM_INT: begin
        if (b == ".") mode = MD_NUM_FRAC;
        else if (e) mode = MD_NUM_EXP_START;
        else if (!d) begin close_number(b); return; end
      end
      MD_NUM_FRAC: begin
        if (e) mode = MD_NUM_EXP_START;
        else if (!d) begin close_number(b); return; end
      end
      MD_NUM_EXP_START: begin
        if (d || b == "+" || b == "-") mode = MD_NUM_EXP;
        else begin close_number(b); return; end
      end
      default: begin
        if (!d) begin close_number(b); return; end
      end
    endcase
    put_byte(TK_NUMBER, b);
  endtask

  task automatic hex_char(logic [7:0] b, bit low);
    int v;
    if (is_dig(b)) v = b - "0";
    else if (b >= "a" && b <= "f") v = b - "a" + 10;
    else if (b >= "A" && b <= "F") v = b - "A" + 10;
    else v = -1;
    if (v < 0) begin
      raise(low ? ER_SURROGATE : ER_UNICODE);
      return;
    end
    hacc = {hacc[11:0], v[3:0]};
    hcnt++;
    if (hcnt < 4) return;
    if (!low) begin
      if (hacc >= 16'hD800 && hacc <= 16'hDBFF) begin
        hsur = hacc;
        mode = MD_PAIR_BS;
      end else begin
        put_codepoint(32'(hacc));
        mode = MD_STR;
      end
      return;
    end
    if (hacc < 16'hDC00 || hacc > 16'hDFFF) begin
      raise(ER_SURROGATE);
      return;
    end
    put_codepoint(32'h10000 + ((int'(hsur) - 'hD800) << 10) + (int'(hacc) - 'hDC00));
    mode = MD_STR;
  endtask

  task automatic literal_char(logic [7:0] b);
    string w;
    if (mode == MD_LIT_T) w = "true";
    else if (mode == MD_LIT_F) w = "false";
    else w = "null";
    if (lidx >= w.len() || b != w[lidx]) begin
      raise(ER_LITERAL);
      return;
    end
    lidx++;
    if (lidx < w.len()) return;
    if (mode == MD_LIT_N) put_event(TK_NULL, 1'b0);
    else put_event(TK_BOOL, mode == MD_LIT_T);
    want_key = in_obj_now();
    mode = MD_IDLE;
  endtask

  task automatic clear_model();
    depth = 0; want_key = 0; mode = MD_IDLE; sep = 0; hacc = 0; hsur = 0;
    hcnt = 0; lidx = 0; in_key = 0; stopped = 0;
  endtask

  task automatic end_of_doc();
    if (!stopped) begin
      case (mode)
        MD_IDLE: ;
        MD_STR: raise(ER_UNTERM_STR);
        MD_ESC: raise(ER_UNTERM_ESC);
        MD_HEX: raise(ER_UNICODE);
        MD_PAIR_BS: begin put_codepoint(32'(hsur)); raise(ER_UNTERM_STR); end
        MD_PAIR_U: begin put_codepoint(32'(hsur)); raise(ER_UNTERM_ESC); end
        MD_LO_HEX: raise(ER_SURROGATE);
        MD_NUM_SIGN: raise(ER_NUMBER);
        MD_NUM_INT, MD_NUM_FRAC, MD_NUM_EXP_START, MD_NUM_EXP:
          put_event(TK_NUMBER, 1'b0);
        default: raise(ER_LITERAL);
      endcase
    end
    put_event(TK_END, 1'b0);
    clear_model();
  endtask

  task automatic tokenize_beat(logic [7:0] b, logic eod);
    int first;
    first = expected_results.size();
    step_cnt = 0;
    if (eod) begin
      end_of_doc();
    end else if (!stopped) begin
      case (mode)
        MD_IDLE: between_tokens(b);
        MD_STR: string_char(b);
        MD_ESC: escape_char(b);
        MD_HEX: hex_char(b, 0);
        MD_PAIR_BS: begin
          if (b == "\\") begin
            mode = MD_PAIR_U;
          end else begin
            put_codepoint(32'(hsur));
            mode = MD_STR;
            string_char(b);
          end
        end
        MD_PAIR_U: begin
          if (b == "u") begin
            mode = MD_LO_HEX; hacc = 0; hcnt = 0;
          end else begin
            put_codepoint(32'(hsur));
            mode = MD_STR;
            escape_char(b);
          end
        end
        MD_LO_HEX: hex_char(b, 1);
        MD_NUM_SIGN, MD_NUM_INT, MD_NUM_FRAC, MD_NUM_EXP_START, MD_NUM_EXP:
          number_char(b);
        default: literal_char(b);
      endcase
    end
    if (expected_results.size() > first)
      expected_results[expected_results.size()-1].last = 1'b1;
  endtask

  // Stimulus helpers.
  int corrupt_pct = 0;

  task automatic push_byte(logic [7:0] b);
    in_beat_t x;
    x.data = ($urandom_range(0, 99) < corrupt_pct) ? 8'($urandom) : b;
    x.eod = 1'b0;
    pending_beats.push_back(x);
  endtask

  task automatic push_text(string s);
    for (int i = 0; i < s.len(); i++) push_byte(s[i]);
  endtask

  task automatic push_end();
    in_beat_t x;
    x.data = 8'($urandom);
    x.eod = 1'b1;
    pending_beats.push_back(x);
  endtask

  task automatic gen_string();
    string hx;
    int n;
    push_byte("\"");
    n = $urandom_range(0, 4);
    for (int i = 0; i < n; i++) begin
      case ($urandom_range(0, 7))
        0: push_text("\\n");
        1: push_text("\\\"");
        2: begin
          hx = $sformatf("\\u%04x", $urandom_range(0, 16'hD7FF));
          push_text(hx);
        end
        3: begin
          hx = $sformatf("\\u%04X\\u%04x", $urandom_range(16'hD800, 16'hDBFF),
                         $urandom_range(16'hDC00, 16'hDFFF));
          push_text(hx);
        end
        4: push_byte(8'($urandom_range(8'h80, 8'hFF)));
        default: push_byte(8'($urandom_range("a", "z")));
      endcase
    end
    push_byte("\"");
  endtask

  task automatic gen_number();
    if ($urandom_range(0, 1)) push_byte("-");
    push_byte(8'($urandom_range("0", "9")));
    if ($urandom_range(0, 1)) push_byte(8'($urandom_range("0", "9")));
    if ($urandom_range(0, 2) == 0) begin
      push_byte(".");
      push_byte(8'($urandom_range("0", "9")));
    end
    if ($urandom_range(0, 3) == 0) begin
      push_byte($urandom_range(0, 1) ? "e" : "E");
      if ($urandom_range(0, 1)) push_byte($urandom_range(0, 1) ? "+" : "-");
      push_byte(8'($urandom_range("0", "9")));
    end
  endtask

  task automatic gen_value(int lvl);
    int n, sel;
    sel = (lvl > 3) ? $urandom_range(2, 7) : $urandom_range(0, 7);
    case (sel)
      0, 1: begin
        push_byte(sel == 0 ? "{" : "[");
        n = $urandom_range(0, 3);
        for (int i = 0; i < n; i++) begin
          if (i > 0) push_byte(",");
          if ($urandom_range(0, 3) == 0) push_byte(" ");
          if (sel == 0) begin
            gen_string();
            push_byte(":");
          end
          gen_value(lvl + 1);
        end
        push_byte(sel == 0 ? "}" : "]");
      end
      2, 3: gen_string();
      4, 5: gen_number();
      6: push_text($urandom_range(0, 1) ? "true" : "false");
      default: push_text("null");
    endcase
  endtask

  // Driver.
  always @(posedge clk) begin
    in_beat_t nb;
    if (!rst) begin
      if (s_tvalid && s_tready) begin
        tokenize_beat(s_tdata, s_tlast);
        beats_sent++;
      end
      if (!s_tvalid || s_tready) begin
        if (tx_gap > 0) begin
          tx_gap <= tx_gap - 1;
          s_tvalid <= 1'b0;
        end else if (pending_beats.size() > 0) begin
          nb = pending_beats.pop_front();
          s_tdata <= nb.data;
          s_tlast <= nb.eod;
          s_tvalid <= 1'b1;
          if (pending_beats.size() > quiet_after && $urandom_range(0, 9) == 0)
            tx_gap <= $urandom_range(1, 12);
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // Monitor and receiver.
  always @(posedge clk) begin
    tok_res_t e;
    if (!rst) begin
      if (m_tvalid && m_tready) begin
        results_seen++;
        if (expected_results.size() == 0) begin
          $display("%0t: unexpected result, expected none, actual tdata=%h user=%b last=%b",
                   $time, m_tdata, m_tuser, m_tlast);
          mismatches++;
        end else begin
          e = expected_results.pop_front();
          if (m_tuser !== e.kind || m_tdata[3:0] !== e.tok || m_tdata[11:4] !== e.vb ||
              m_tdata[12] !== e.bv || m_tdata[21:13] !== e.dp ||
              m_tdata[25:22] !== e.ec || m_tlast !== e.last) begin
            $display("%0t: mismatch, expected kind=%b tok=%0d byte=%h bool=%b depth=%0d err=%0d last=%b",
                     $time, e.kind, e.tok, e.vb, e.bv, e.dp, e.ec, e.last);
            $display("%0t:           actual kind=%b tok=%0d byte=%h bool=%b depth=%0d err=%0d last=%b",
                     $time, m_tuser, m_tdata[3:0], m_tdata[11:4], m_tdata[12],
                     m_tdata[21:13], m_tdata[25:22], m_tlast);
            mismatches++;
          end
        end
      end
      // One long hold-off lets the block back up into its input.
      if (!hold_done && results_seen >= 60) begin
        hold_done <= 1;
        hold_cnt <= 300;
        m_tready <= 1'b0;
      end else if (hold_cnt > 0) begin
        hold_cnt <= hold_cnt - 1;
        m_tready <= (hold_cnt == 1);
      end else if (rx_gap > 0) begin
        rx_gap <= rx_gap - 1;
        m_tready <= (rx_gap == 1);
      end else if (pending_beats.size() > quiet_after && $urandom_range(0, 9) == 0) begin
        rx_gap <= $urandom_range(1, 12);
        m_tready <= 1'b0;
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  // Watchdog on cycles with no accepted beat on either side.
  always @(posedge clk) begin
    if (!rst) begin
      if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= 3000) begin
        $display("[json_stream_tokenizer] ERROR");
        $finish;
      end
    end
  end

  initial begin
    string b0;
    int start_sz;
    clear_model();
    // Directed documents: nesting, all scalars, escapes and surrogates.
    push_text("{\"k\":[-1.5e+3,true,false,null,0]}");
    push_end();
    push_text("[\"\\u00e9\\u20AC\\ud83d\\ude00\\ud800x\\ud801\\n\\/\"]");
    push_end();
    // Error paths and end-of-input cases, each ended by the end marker.
    push_text("[,,"); push_end();
    push_text("::"); push_end();
    push_byte(8'h00); push_end();
    push_text("]}[}"); push_end();
    push_text("tx"); push_end();
    push_text("-a"); push_end();
    push_text("\"\\q"); push_end();
    push_text("\"\\u12g"); push_end();
    push_text("\"\\ud800\\u0041"); push_end();
    push_text("\"\\ud800\\uzz"); push_end();
    push_text("\"ab"); push_end();
    push_text("\"\\"); push_end();
    push_text("\"\\u12"); push_end();
    push_text("\"\\ud800"); push_end();
    push_text("\"\\ud800\\"); push_end();
    push_text("\"\\ud800\\u"); push_end();
    push_text("-"); push_end();
    push_text("12"); push_end();
    push_text("fal"); push_end();
    push_text("1,"); push_end();
    // Nesting past the limit.
    for (int i = 0; i <= MAX_NEST; i++) push_byte(($urandom_range(0, 1)) ? "[" : "{");
    push_end();
    start_sz = pending_beats.size();
    while (pending_beats.size() < start_sz + 40) begin
      case ($urandom_range(0, 9))
        0: begin
          for (int i = 0; i < 6; i++) push_byte(8'($urandom));
        end
        1, 2: begin
          corrupt_pct = 5;
          gen_value(0);
          corrupt_pct = 0;
        end
        default: gen_value(0);
      endcase
      push_end();
    end
    quiet_after = 0;
    // The tail of the run goes without idling.
    quiet_after = 60;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    wait (pending_beats.size() == 0 && !s_tvalid);
    wait (expected_results.size() == 0);
    repeat (20) @(posedge clk);
    if (mismatches == 0 && expected_results.size() == 0) begin
      $display("[json_stream_tokenizer] OK");
    end else begin
      $display("[json_stream_tokenizer] ERROR");
    end
    $finish;
  end

endmodule
